/* hw/rtl/fsd_pkg.sv */
// Shared types and constants for the field-sequential segment driver.
`default_nettype none

package fsd_pkg;

    localparam int SEGMENTS_DEFAULT = 64;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_FRAME = 1'b1;

    localparam logic [2:0] COL_BLUE  = 3'd1;
    localparam logic [2:0] COL_RED   = 3'd2;
    localparam logic [2:0] COL_GREEN = 3'd4;

    localparam logic [3:0] PERIODS_RESET = 4'd3;

    // controller -> datapath
    typedef struct packed {
        logic write;   // store the input word in the table
        logic start;   // begin a frame walk
        logic step;    // advance the walk by one entry
    } fsd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic byte_blocked;  // a finished word cannot enter the output register
        logic frame_done;    // last word of the frame is being loaded
    } fsd_status_t;

endpackage

`default_nettype wire

/* hw/rtl/fsd_ctrl.sv */
// Frame controller: idle/run sequencing and walk stepping.
`default_nettype none

module fsd_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    input  wire               opcode,
    output logic              in_ready,
    output fsd_pkg::fsd_cmd_t cmd,
    input  fsd_pkg::fsd_status_t status
);
    import fsd_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;
    logic   accept;

    assign accept   = in_valid && in_ready_reg;
    assign in_ready = in_ready_reg;

    always_comb
    begin
        cmd.write = accept && (opcode == OP_WRITE);
        cmd.start = accept && (opcode == OP_FRAME);
        cmd.step  = (state_reg == ST_RUN) && !status.byte_blocked;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (opcode == OP_FRAME))
                    begin
                        state_reg    <= ST_RUN;
                        in_ready_reg <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (status.frame_done)
                    begin
                        state_reg    <= ST_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= ST_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fsd_datapath.sv */
// Datapath: segment table, walk pipeline, byte packer, output register, color state.
`default_nettype none

module fsd_datapath #(
    parameter int SEGMENTS = fsd_pkg::SEGMENTS_DEFAULT
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  fsd_pkg::fsd_cmd_t    cmd,
    output fsd_pkg::fsd_status_t status,
    input  wire  [5:0]           seg_index,
    input  wire  [7:0]           seg_value,
    input  wire                  cfg_wr_en,
    input  wire  [3:0]           cfg_wr_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic [7:0]           shift_byte,
    output logic [2:0]           led_mask,
    output logic                 polarity_pin,
    output logic                 last
);
    import fsd_pkg::*;

    localparam int AW = $clog2(SEGMENTS);
    localparam int IW = (AW > 6) ? AW : 6;
    localparam int CW = IW + 1;

    // table
    logic [7:0]          mem [SEGMENTS];
    logic [SEGMENTS-1:0] entry_vld_reg;

    // walk pipeline
    logic          issue_act_reg;
    logic [AW-1:0] addr_reg;
    logic          s1_act_reg;
    logic [AW-1:0] s1_idx_reg;
    logic [7:0]    rd_data_reg;
    logic          rd_vld_reg;
    logic [7:0]    acc_reg;

    // frame state
    logic       invert_phase_reg;
    logic       upper_sel_reg;
    logic [2:0] active_color_reg;
    logic [2:0] lit_color_reg;
    logic [3:0] period_count_reg;
    logic [3:0] periods_reg;

    // output register
    logic       out_valid_reg;
    logic [7:0] shift_byte_reg;
    logic [2:0] led_mask_reg;
    logic       polarity_reg;
    logic       last_reg;

    logic [IW-1:0] wr_idx_wide;
    logic [AW-1:0] wr_addr;
    logic          wr_in_range;
    logic [2:0]    nib;
    logic          seg_bit;
    logic [7:0]    acc_next;
    logic          byte_close;
    logic          frame_end;
    logic          load_out;
    logic [3:0]    pc_inc;

    assign wr_idx_wide = IW'(seg_index);
    assign wr_addr     = wr_idx_wide[AW-1:0];
    assign wr_in_range = {1'b0, wr_idx_wide} < CW'(SEGMENTS);

    assign nib        = upper_sel_reg ? rd_data_reg[6:4] : rd_data_reg[2:0];
    assign seg_bit    = rd_vld_reg && !rd_data_reg[7] && (|(nib & active_color_reg));
    assign acc_next   = {acc_reg[6:0], seg_bit};
    assign byte_close = s1_act_reg && (s1_idx_reg[2:0] == 3'd0);
    assign frame_end  = byte_close && (s1_idx_reg == '0);
    assign load_out   = cmd.step && byte_close;
    assign pc_inc     = period_count_reg + 4'd1;

    assign status.byte_blocked = byte_close && out_valid_reg && !out_ready;
    assign status.frame_done   = cmd.step && frame_end;

    assign out_valid    = out_valid_reg;
    assign shift_byte   = shift_byte_reg;
    assign led_mask     = led_mask_reg;
    assign polarity_pin = polarity_reg;
    assign last         = last_reg;

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write && wr_in_range)
        begin
            mem[wr_addr] <= seg_value;
        end
        if (cmd.step && issue_act_reg)
        begin
            rd_data_reg <= mem[addr_reg];
            rd_vld_reg  <= entry_vld_reg[addr_reg];
            s1_idx_reg  <= addr_reg;
        end
    end

    // payload of the output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            shift_byte_reg <= acc_next ^ {8{invert_phase_reg}};
            led_mask_reg   <= frame_end ? lit_color_reg : 3'd0;
            polarity_reg   <= frame_end ? invert_phase_reg : 1'b0;
            last_reg       <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg    <= '0;
            issue_act_reg    <= 1'b0;
            addr_reg         <= '0;
            s1_act_reg       <= 1'b0;
            acc_reg          <= '0;
            invert_phase_reg <= 1'b0;
            upper_sel_reg    <= 1'b0;
            active_color_reg <= COL_BLUE;
            lit_color_reg    <= COL_BLUE;
            period_count_reg <= '0;
            periods_reg      <= PERIODS_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                periods_reg <= cfg_wr_data;
            end

            if (cmd.write && wr_in_range)
            begin
                entry_vld_reg[wr_addr] <= 1'b1;
            end

            // address issue
            if (cmd.start)
            begin
                issue_act_reg <= 1'b1;
                addr_reg      <= AW'(SEGMENTS - 1);
                acc_reg       <= '0;
            end
            else if (cmd.step)
            begin
                s1_act_reg <= issue_act_reg;
                if (issue_act_reg)
                begin
                    if (addr_reg == '0)
                    begin
                        issue_act_reg <= 1'b0;
                    end
                    else
                    begin
                        addr_reg <= addr_reg - AW'(1);
                    end
                end
                if (s1_act_reg)
                begin
                    acc_reg <= byte_close ? 8'd0 : acc_next;
                end
            end

            // output register handshake
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // per-frame state update
            if (cmd.step && frame_end)
            begin
                upper_sel_reg <= !upper_sel_reg;
                if (invert_phase_reg)
                begin
                    invert_phase_reg <= 1'b0;
                    unique case (active_color_reg)
                        COL_BLUE, COL_RED, COL_GREEN:
                        begin
                            lit_color_reg <= active_color_reg;
                            if (pc_inc >= periods_reg)
                            begin
                                period_count_reg <= '0;
                                unique case (active_color_reg)
                                    COL_BLUE:  active_color_reg <= COL_RED;
                                    COL_RED:   active_color_reg <= COL_GREEN;
                                    default:   active_color_reg <= COL_BLUE;
                                endcase
                            end
                            else
                            begin
                                period_count_reg <= pc_inc;
                            end
                        end
                        default:
                        begin
                            active_color_reg <= COL_RED;
                        end
                    endcase
                end
                else
                begin
                    invert_phase_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/field_sequential_segment_driver.sv */
// Top level of the field-sequential color LCD segment driver.
`default_nettype none

// Field-sequential segment driver. An input word with opcode write stores
// seg_value at seg_index in a SEGMENTS-entry table (indexes at or above
// SEGMENTS are dropped) and produces nothing. An input word with opcode
// frame walks the table from the top entry down to entry 0, one entry per
// cycle while the output register can take each finished word, through a
// registered table read, and emits ceil(SEGMENTS/8) output words of packed
// segment bits, the highest index in the MSB. The last word also carries
// the backlight color mask and the polarity pin. While the consumer keeps
// up, the single-port table read, one entry per cycle, sets the length of a
// frame. A slow consumer stalls the walk at each byte boundary; the output
// register holds one finished word so the next input word can be taken
// while the final byte of a frame still waits.
// The table is cleared at reset through per-entry valid bits, so there is
// no clearing pass. periods_per_color is written via cfg_wr_en/cfg_wr_data
// and should only change while the block is idle.
module field_sequential_segment_driver #(
    parameter int SEGMENTS = fsd_pkg::SEGMENTS_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    // input words
    input  wire        in_valid,
    output logic       in_ready,
    input  wire        opcode,
    input  wire  [5:0] seg_index,
    input  wire  [7:0] seg_value,
    // configuration
    input  wire        cfg_wr_en,
    input  wire  [3:0] cfg_wr_data,
    // output words
    output logic       out_valid,
    input  wire        out_ready,
    output logic [7:0] shift_byte,
    output logic [2:0] led_mask,
    output logic       polarity_pin,
    output logic       last
);
    import fsd_pkg::*;

    fsd_cmd_t    cmd;
    fsd_status_t status;

    // sequencing: idle/run, step enable gated by output backpressure
    fsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // table, walk pipeline, packer and color state
    fsd_datapath #(
        .SEGMENTS (SEGMENTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .seg_index    (seg_index),
        .seg_value    (seg_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shift_byte   (shift_byte),
        .led_mask     (led_mask),
        .polarity_pin (polarity_pin),
        .last         (last)
    );

    // a frame word closes the input until its walk finishes
    a_frame_blocks_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_FRAME)) |=> !in_ready
    ) else $error("input still open after frame accepted");

    // the controller reopens the input right after the last byte is loaded
    a_done_reopens: assert property (
        @(posedge clk) disable iff (!rst_n)
        status.frame_done |=> (in_ready && out_valid && last)
    ) else $error("frame end not followed by idle with last word");

    // only the last word carries the backlight and polarity fields
    a_side_fields_last_only: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> ((led_mask == 3'd0) && !polarity_pin)
    ) else $error("side fields set on non-last word");

    // backlight mask is always a single color
    a_led_onehot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> $onehot(led_mask)
    ) else $error("led mask not one-hot");

endmodule

`default_nettype wire

/* test/fsd_frame_checker.sv */
// Frame predictor and output word checker for the segment driver testbench.
module fsd_frame_checker #(
    parameter int SEGMENTS = fsd_pkg::SEGMENTS_DEFAULT
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    input  wire        in_ready,
    input  wire        opcode,
    input  wire  [5:0] seg_index,
    input  wire  [7:0] seg_value,
    input  wire        cfg_wr_en,
    input  wire  [3:0] cfg_wr_data,
    input  wire        out_valid,
    input  wire        out_ready,
    input  wire  [7:0] shift_byte,
    input  wire  [2:0] led_mask,
    input  wire        polarity_pin,
    input  wire        last,
    output int         fail_count,
    output int         words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsd_pkg::*;

    typedef struct packed {
        logic [7:0] shift_byte;
        logic [2:0] led_mask;
        logic       polarity_pin;
        logic       last;
    } frame_word_t;

    // shadow copy of the block's state
    logic [7:0]  seg_table [SEGMENTS];
    logic        invert_phase;
    logic        upper_sel;
    logic [2:0]  active_color;
    logic [2:0]  lit_color;
    logic [3:0]  period_count;
    logic [3:0]  periods_per_color;

    frame_word_t frame_words_q[$];
    frame_word_t got_word;
    frame_word_t want_word;

    function automatic void advance_color(input logic [2:0] this_col,
                                          input logic [2:0] next_col);
        lit_color    = this_col;
        period_count = period_count + 4'd1;
        if (period_count >= periods_per_color)
        begin
            active_color = next_col;
            period_count = '0;
        end
    endfunction

    // walk the table top-down, queue one word per eight segments
    function automatic void render_frame();
        logic [7:0]  acc;
        logic [2:0]  nib;
        frame_word_t w;
        acc = '0;
        for (int i = SEGMENTS - 1; i >= 0; i--)
        begin
            acc = {acc[6:0], 1'b0};
            if (!seg_table[i][7])
            begin
                nib = upper_sel ? seg_table[i][6:4] : seg_table[i][2:0];
                if ((nib & active_color) != 3'd0)
                    acc[0] = 1'b1;
            end
            if (i % 8 == 0)
            begin
                w.shift_byte   = invert_phase ? ~acc : acc;
                w.led_mask     = (i == 0) ? lit_color : 3'd0;
                w.polarity_pin = (i == 0) ? invert_phase : 1'b0;
                w.last         = (i == 0);
                frame_words_q.push_back(w);
                acc = '0;
            end
        end
        upper_sel = ~upper_sel;
        if (invert_phase)
        begin
            case (active_color)
                COL_BLUE:  advance_color(COL_BLUE, COL_RED);
                COL_RED:   advance_color(COL_RED, COL_GREEN);
                COL_GREEN: advance_color(COL_GREEN, COL_BLUE);
                default:   active_color = COL_RED;
            endcase
            invert_phase = 1'b0;
        end
        else
        begin
            invert_phase = 1'b1;
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (seg_table[k])
                seg_table[k] = '0;
            invert_phase      = 1'b0;
            upper_sel         = 1'b0;
            active_color      = COL_BLUE;
            lit_color         = COL_BLUE;
            period_count      = '0;
            periods_per_color = PERIODS_RESET;
            frame_words_q.delete();
            words_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                periods_per_color = cfg_wr_data;
            // input first: a word leaving this edge always belongs to an older frame
            if (in_valid && in_ready)
            begin
                if (opcode == OP_WRITE)
                begin
                    if (seg_index < SEGMENTS)
                        seg_table[seg_index] = seg_value;
                end
                else
                begin
                    render_frame();
                end
            end
            if (out_valid && out_ready)
            begin
                got_word = '{shift_byte, led_mask, polarity_pin, last};
                if (frame_words_q.size() == 0)
                begin
                    $error("unexpected output word: shift_byte=0x%0h last=%0b",
                           shift_byte, last);
                    fail_count++;
                end
                else
                begin
                    want_word = frame_words_q.pop_front();
                    check_field("shift_byte", 32'(want_word.shift_byte),
                                32'(got_word.shift_byte));
                    check_field("led_mask", 32'(want_word.led_mask),
                                32'(got_word.led_mask));
                    check_field("polarity_pin", 32'(want_word.polarity_pin),
                                32'(got_word.polarity_pin));
                    check_field("last", 32'(want_word.last), 32'(got_word.last));
                end
            end
            words_pending <= frame_words_q.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Stimulus, clock/reset and pass/fail verdict for the segment driver.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fsd_pkg::*;

    // long enough for a full table walk, with slack on top
    localparam int SETTLE_CYCLES = SEGMENTS_DEFAULT + 8;
    localparam int ITEMS_PER_PHASE = 27;
    localparam int MAX_GAP = 20;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       opcode = OP_WRITE;
    logic [5:0] seg_index = '0;
    logic [7:0] seg_value = '0;
    logic       cfg_wr_en = 1'b0;
    logic [3:0] cfg_wr_data = '0;
    logic       out_ready = 1'b0;

    wire        in_ready;
    wire        out_valid;
    wire  [7:0] shift_byte;
    wire  [2:0] led_mask;
    wire        polarity_pin;
    wire        last;

    int fail_count;
    int words_pending;

    // idle odds in percent, changed per phase
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    field_sequential_segment_driver dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .seg_index    (seg_index),
        .seg_value    (seg_value),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shift_byte   (shift_byte),
        .led_mask     (led_mask),
        .polarity_pin (polarity_pin),
        .last         (last)
    );

    fsd_frame_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .seg_index     (seg_index),
        .seg_value     (seg_value),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .shift_byte    (shift_byte),
        .led_mask      (led_mask),
        .polarity_pin  (polarity_pin),
        .last          (last),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // consumer side: random back-pressure, odds set by the current phase
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // Offer one input word and hold it until the handshake completes.
    // Valid only drops when a gap is taken, so it is never lowered and
    // raised in the same step.
    task automatic send_word(input logic op, input logic [5:0] idx,
                             input logic [7:0] val);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        opcode    <= op;
        seg_index <= idx;
        seg_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Stop sending until every queued output word is back, then let the
    // walk settle in case a trailing table write is still in flight.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // only called while the block is idle
    task automatic set_periods(input logic [3:0] periods);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= periods;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [3:0] period_plan [8];
        logic [7:0] val;
        int         pick;

        period_plan = '{4'd0, 4'd15, 4'd1, 4'd2, 4'd15, 4'd0, 4'd7, 4'd5};
        period_plan[7] = 4'($urandom_range(15));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner segment words, then frames to see both nibble
        // selects and both polarities under the reset period count.
        send_word(OP_WRITE, 6'd63, 8'h70);   // odd fields, all colors
        send_word(OP_WRITE, 6'd62, 8'h07);   // even fields, all colors
        send_word(OP_WRITE, 6'd56, 8'h12);   // odd blue, even red
        send_word(OP_WRITE, 6'd7,  8'hF7);   // disabled despite color bits
        send_word(OP_WRITE, 6'd0,  8'h08);   // unused bit only, never lit
        send_word(OP_WRITE, 6'd1,  8'h44);   // green in both fields
        send_word(OP_WRITE, 6'd31, 8'h77);
        repeat (4) send_word(OP_FRAME, 6'd0, 8'h00);
        send_word(OP_WRITE, 6'd63, 8'h00);   // overwrite with all-clear
        send_word(OP_WRITE, 6'd0,  8'hFF);   // fully set, disabled
        send_word(OP_FRAME, 6'd63, 8'hFF);   // payload ignored on frames
        repeat (3) send_word(OP_FRAME, 6'd0, 8'h00);

        // Random phases: idle/stall profile rotates, period count changes
        // between phases while the block is drained.
        for (int ph = 0; ph < 8; ph++)
        begin
            wait_idle();
            set_periods(period_plan[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(99);
                val  = 8'($urandom());
                // keep most segments enabled so frames carry information
                if ($urandom_range(3) != 0)
                    val[7] = 1'b0;
                if (pick < 50)
                    send_word(OP_WRITE, 6'($urandom_range(63)), val);
                else
                    send_word(OP_FRAME, 6'($urandom_range(63)), val);
            end
        end

        wait_idle();
        @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // hard stop far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/fsd_pkg.sv
hw/rtl/fsd_ctrl.sv
hw/rtl/fsd_datapath.sv
hw/rtl/field_sequential_segment_driver.sv
test/fsd_frame_checker.sv
test/tb_top.sv
